// ===== rtl/core/rsab_pkg.sv =====
package rsab_pkg;

    // Sprite geometry and screen placement.
    localparam int SPRITE_WIDTH  = 63;
    localparam int SPRITE_HEIGHT = 240;
    localparam int PIVOT_COL     = 32;
    localparam int PIVOT_ROW     = 50;
    localparam int CENTER_X      = 240;
    localparam int CENTER_Y      = 240;

    localparam int TEXEL_COUNT = SPRITE_WIDTH * SPRITE_HEIGHT;
    localparam int ADDR_W      = $clog2(TEXEL_COUNT);
    localparam int X_W         = $clog2(SPRITE_WIDTH);
    localparam int Y_W         = $clog2(SPRITE_HEIGHT);

    // Field widths.
    localparam int COORD_W = 9;
    localparam int COLOR_W = 32;
    localparam int TRIG_W  = 16;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SIN = CFG_IDX_W'(1);
    localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sh4000;
    localparam logic signed [TRIG_W-1:0] SIN_RESET = 16'sh0000;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_BLEND = 1'b1
    } t_opcode;

    // Texel store access issued by the coordinate pipeline. Loads write,
    // blends read, both at the same stage so that store order follows
    // item order.
    typedef struct packed {
        logic               valid;
        t_opcode            op;
        logic               hit;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
    } t_mem_req;

endpackage

// ===== rtl/core/rsab_in_if.sv =====
interface rsab_in_if;
    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic [rsab_pkg::COORD_W-1:0]    col;
    logic [rsab_pkg::COORD_W-1:0]    row;
    logic [rsab_pkg::COLOR_W-1:0]    color;

    modport source (output valid, output opcode, output col, output row, output color,
                    input ready);
    modport sink   (input valid, input opcode, input col, input row, input color,
                    output ready);
endinterface

// ===== rtl/core/rsab_out_if.sv =====
interface rsab_out_if;
    logic                            valid;
    logic                            ready;
    logic [rsab_pkg::COLOR_W-1:0]    pixel_out;
    logic                            changed;

    modport source (output valid, output pixel_out, output changed, input ready);
    modport sink   (input valid, input pixel_out, input changed, output ready);
endinterface

// ===== rtl/core/rsab_cfg_if.sv =====
interface rsab_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rsab_pkg::CFG_IDX_W-1:0]    index;
    logic [rsab_pkg::TRIG_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rsab_ram.sv =====
module rsab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rsab_map.sv =====
module rsab_map (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  rsab_pkg::t_opcode                    i_opcode,
    input  logic [rsab_pkg::COORD_W-1:0]         i_col,
    input  logic [rsab_pkg::COORD_W-1:0]         i_row,
    input  logic [rsab_pkg::COLOR_W-1:0]         i_color,
    input  logic signed [rsab_pkg::TRIG_W-1:0]   i_cos,
    input  logic signed [rsab_pkg::TRIG_W-1:0]   i_sin,
    output rsab_pkg::t_mem_req                   o_req
);

    localparam int DX_W   = rsab_pkg::COORD_W + 1;
    localparam int PROD_W = DX_W + rsab_pkg::TRIG_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int Q_W    = SUM_W - 14;
    localparam int POS_W  = Q_W + 1;

    // Stage 1: offsets from the screen center.
    logic                              r_s1_valid;
    rsab_pkg::t_opcode                 r_s1_op;
    logic [rsab_pkg::COORD_W-1:0]      r_s1_col;
    logic [rsab_pkg::COORD_W-1:0]      r_s1_row;
    logic [rsab_pkg::COLOR_W-1:0]      r_s1_color;
    logic signed [DX_W-1:0]            r_s1_dx;
    logic signed [DX_W-1:0]            r_s1_dy;

    // Stage 2: the four rotation products.
    logic                              r_s2_valid;
    rsab_pkg::t_opcode                 r_s2_op;
    logic [rsab_pkg::COORD_W-1:0]      r_s2_col;
    logic [rsab_pkg::COORD_W-1:0]      r_s2_row;
    logic [rsab_pkg::COLOR_W-1:0]      r_s2_color;
    logic signed [PROD_W-1:0]          r_s2_xc;
    logic signed [PROD_W-1:0]          r_s2_ys;
    logic signed [PROD_W-1:0]          r_s2_yc;
    logic signed [PROD_W-1:0]          r_s2_xs;

    // Stage 3: rotated coordinates in Q14 with the rounding half added.
    logic                              r_s3_valid;
    rsab_pkg::t_opcode                 r_s3_op;
    logic [rsab_pkg::COORD_W-1:0]      r_s3_col;
    logic [rsab_pkg::COORD_W-1:0]      r_s3_row;
    logic [rsab_pkg::COLOR_W-1:0]      r_s3_color;
    logic signed [SUM_W-1:0]           r_s3_u;
    logic signed [SUM_W-1:0]           r_s3_v;

    // Stage 4: sprite coordinates and the inside test.
    logic                              r_s4_valid;
    rsab_pkg::t_opcode                 r_s4_op;
    logic                              r_s4_hit;
    logic [rsab_pkg::X_W-1:0]          r_s4_x;
    logic [rsab_pkg::Y_W-1:0]          r_s4_y;
    logic [rsab_pkg::COLOR_W-1:0]      r_s4_color;

    rsab_pkg::t_mem_req                r_s5_req;

    logic signed [DX_W-1:0]            n_dx;
    logic signed [DX_W-1:0]            n_dy;
    logic signed [Q_W-1:0]             n_qu;
    logic signed [Q_W-1:0]             n_qv;
    logic signed [POS_W-1:0]           n_sx;
    logic signed [POS_W-1:0]           n_sy;
    logic                              n_hit;
    logic [rsab_pkg::X_W-1:0]          n_x;
    logic [rsab_pkg::Y_W-1:0]          n_y;

    assign n_dx = $signed({1'b0, i_col}) - $signed(DX_W'(rsab_pkg::CENTER_X));
    assign n_dy = $signed({1'b0, i_row}) - $signed(DX_W'(rsab_pkg::CENTER_Y));

    // Truncation toward zero: bias negative values before the arithmetic shift.
    always_comb begin
        n_qu = Q_W'((r_s3_u + (r_s3_u[SUM_W-1] ? SUM_W'(16383) : SUM_W'(0))) >>> 14);
        n_qv = Q_W'((r_s3_v + (r_s3_v[SUM_W-1] ? SUM_W'(16383) : SUM_W'(0))) >>> 14);
        n_sx = POS_W'(n_qu) + $signed(POS_W'(rsab_pkg::PIVOT_COL));
        n_sy = POS_W'(n_qv) + $signed(POS_W'(rsab_pkg::PIVOT_ROW));
        if (r_s3_op == rsab_pkg::OP_LOAD) begin
            n_hit = (r_s3_col < rsab_pkg::COORD_W'(rsab_pkg::SPRITE_WIDTH))
                 && (r_s3_row < rsab_pkg::COORD_W'(rsab_pkg::SPRITE_HEIGHT));
            n_x   = rsab_pkg::X_W'(r_s3_col);
            n_y   = rsab_pkg::Y_W'(r_s3_row);
        end else begin
            n_hit = !n_sx[POS_W-1] && !n_sy[POS_W-1]
                 && (n_sx < $signed(POS_W'(rsab_pkg::SPRITE_WIDTH)))
                 && (n_sy < $signed(POS_W'(rsab_pkg::SPRITE_HEIGHT)));
            n_x   = rsab_pkg::X_W'(n_sx);
            n_y   = rsab_pkg::Y_W'(n_sy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_s3_valid     <= 1'b0;
            r_s4_valid     <= 1'b0;
            r_s5_req.valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid     <= i_valid;
            r_s2_valid     <= r_s1_valid;
            r_s3_valid     <= r_s2_valid;
            r_s4_valid     <= r_s3_valid;
            r_s5_req.valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_op    <= i_opcode;
            r_s1_col   <= i_col;
            r_s1_row   <= i_row;
            r_s1_color <= i_color;
            r_s1_dx    <= n_dx;
            r_s1_dy    <= n_dy;

            r_s2_op    <= r_s1_op;
            r_s2_col   <= r_s1_col;
            r_s2_row   <= r_s1_row;
            r_s2_color <= r_s1_color;
            r_s2_xc    <= PROD_W'(r_s1_dx) * PROD_W'(i_cos);
            r_s2_ys    <= PROD_W'(r_s1_dy) * PROD_W'(i_sin);
            r_s2_yc    <= PROD_W'(r_s1_dy) * PROD_W'(i_cos);
            r_s2_xs    <= PROD_W'(r_s1_dx) * PROD_W'(i_sin);

            r_s3_op    <= r_s2_op;
            r_s3_col   <= r_s2_col;
            r_s3_row   <= r_s2_row;
            r_s3_color <= r_s2_color;
            r_s3_u     <= SUM_W'(r_s2_xc) + SUM_W'(r_s2_ys) + SUM_W'(8192);
            r_s3_v     <= SUM_W'(r_s2_yc) - SUM_W'(r_s2_xs) + SUM_W'(8192);

            r_s4_op    <= r_s3_op;
            r_s4_hit   <= n_hit;
            r_s4_x     <= n_x;
            r_s4_y     <= n_y;
            r_s4_color <= r_s3_color;

            r_s5_req.op    <= r_s4_op;
            r_s5_req.hit   <= r_s4_hit;
            r_s5_req.addr  <= rsab_pkg::ADDR_W'(r_s4_y)
                            * rsab_pkg::ADDR_W'(rsab_pkg::SPRITE_WIDTH)
                            + rsab_pkg::ADDR_W'(r_s4_x);
            r_s5_req.color <= r_s4_color;
        end
    end

    assign o_req = r_s5_req;

endmodule

// ===== rtl/core/rsab_blend.sv =====
module rsab_blend (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  rsab_pkg::t_mem_req               i_req,
    input  logic [rsab_pkg::COLOR_W-1:0]     i_texel,
    output logic                             o_valid,
    output logic [rsab_pkg::COLOR_W-1:0]     o_pixel,
    output logic                             o_changed
);

    typedef enum logic [1:0] {
        BM_PASS,
        BM_COPY,
        BM_MIX
    } t_blend_mode;

    // Floor division by 255, exact for every dividend up to 255 * 255, which
    // covers the largest blend sum.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'd1 + 17'(x[15:8]);
        return t[15:8];
    endfunction

    logic                            r_s6_valid;
    logic                            r_s6_hit;
    logic [rsab_pkg::COLOR_W-1:0]    r_s6_dst;

    logic                            r_s7_valid;
    t_blend_mode                     r_s7_mode;
    logic [rsab_pkg::COLOR_W-1:0]    r_s7_dst;
    logic [rsab_pkg::COLOR_W-1:0]    r_s7_tex;
    logic [15:0]                     r_s7_sum [3];

    logic                            r_out_valid;
    logic [rsab_pkg::COLOR_W-1:0]    r_out_pixel;
    logic                            r_out_changed;

    logic [7:0]                      n_alpha;
    t_blend_mode                     n_mode;
    logic [15:0]                     n_sum [3];
    logic [rsab_pkg::COLOR_W-1:0]    n_pixel;

    assign n_alpha = i_texel[31:24];

    always_comb begin
        if (!r_s6_hit || n_alpha == 8'd0) begin
            n_mode = BM_PASS;
        end else if (n_alpha == 8'hFF) begin
            n_mode = BM_COPY;
        end else begin
            n_mode = BM_MIX;
        end
        for (int ch = 0; ch < 3; ch++) begin
            n_sum[ch] = 16'(i_texel[ch*8 +: 8]) * 16'(n_alpha)
                      + 16'(r_s6_dst[ch*8 +: 8]) * 16'(8'hFF - n_alpha);
        end
    end

    always_comb begin
        case (r_s7_mode)
            BM_COPY: n_pixel = r_s7_tex;
            BM_MIX:  n_pixel = {8'hFF, div255(r_s7_sum[2]), div255(r_s7_sum[1]),
                                div255(r_s7_sum[0])};
            default: n_pixel = r_s7_dst;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid  <= 1'b0;
            r_s7_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_s6_valid  <= i_req.valid && (i_req.op == rsab_pkg::OP_BLEND);
            r_s7_valid  <= r_s6_valid;
            r_out_valid <= r_s7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s6_hit      <= i_req.hit;
            r_s6_dst      <= i_req.color;
            r_s7_mode     <= n_mode;
            r_s7_dst      <= r_s6_dst;
            r_s7_tex      <= i_texel;
            r_s7_sum      <= n_sum;
            r_out_pixel   <= n_pixel;
            r_out_changed <= (r_s7_mode != BM_PASS);
        end
    end

    assign o_valid   = r_out_valid;
    assign o_pixel   = r_out_pixel;
    assign o_changed = r_out_changed;

endmodule

// ===== rtl/core/rotated_sprite_alpha_blend.sv =====
// Rotated sprite alpha blender.
// The input channel carries two kinds of beat. A load beat (opcode 0) writes
// one ARGB8888 texel at sprite column col and row row; it produces no output
// beat, and loads outside the sprite are dropped. A blend beat (opcode 1)
// carries a screen pixel and its current color, and produces exactly one
// output beat: the pixel after the inverse-rotated sprite is blended over it,
// plus a flag that tells whether a nonzero-alpha texel covered it.
// The configuration channel writes the Q1.14 cosine (index 0) and sine
// (index 1); it is always ready. The user must see that it is written only
// while the block is idle; the block does not enforce this. Every texel
// must be loaded before a blend reads it. Throughput is one beat per clock
// while the receiver is not stalling. Four stages map the coordinate, one
// stage addresses the texel store, its registered read is the sixth, then
// the blend sum and the divide by 255 finish the item.
// The whole pipeline advances together; when the receiver holds ready low with
// a result waiting, every stage holds and the input drops ready, so nothing is
// lost or repeated. Reset clears all valid bits and restores cosine 1.0 and
// sine 0; the texel store is not cleared.
module rotated_sprite_alpha_blend (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsab_cfg_if.sink  i_cfg,
    rsab_in_if.sink   i_pix,
    rsab_out_if.source o_pix
);

    logic signed [rsab_pkg::TRIG_W-1:0]  r_cos;
    logic signed [rsab_pkg::TRIG_W-1:0]  r_sin;

    logic                                en;
    rsab_pkg::t_mem_req                  mem_req;
    logic                                mem_we;
    logic                                mem_re;
    logic [rsab_pkg::COLOR_W-1:0]        texel;
    logic                                out_valid;

    // Configuration registers; unknown indexes are ignored.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= rsab_pkg::COS_RESET;
            r_sin <= rsab_pkg::SIN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rsab_pkg::REG_COS: r_cos <= i_cfg.data;
                rsab_pkg::REG_SIN: r_sin <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // One enable moves every stage; it is low only while a finished result
    // waits at the output and the receiver is stalling.
    assign en          = !out_valid || o_pix.ready;
    assign i_pix.ready = en;

    rsab_map u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_pix.valid),
        .i_opcode (rsab_pkg::t_opcode'(i_pix.opcode)),
        .i_col    (i_pix.col),
        .i_row    (i_pix.row),
        .i_color  (i_pix.color),
        .i_cos    (r_cos),
        .i_sin    (r_sin),
        .o_req    (mem_req)
    );

    // Loads write and blends read at the same stage, so store accesses keep
    // the order of the beats.
    assign mem_we = en && mem_req.valid && mem_req.hit && (mem_req.op == rsab_pkg::OP_LOAD);
    assign mem_re = en && mem_req.valid && mem_req.hit && (mem_req.op == rsab_pkg::OP_BLEND);

    rsab_ram #(
        .WIDTH (rsab_pkg::COLOR_W),
        .DEPTH (rsab_pkg::TEXEL_COUNT)
    ) u_texels (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_req.addr),
        .i_wdata (mem_req.color),
        .i_re    (mem_re),
        .i_raddr (mem_req.addr),
        .o_rdata (texel)
    );

    rsab_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_req     (mem_req),
        .i_texel   (texel),
        .o_valid   (out_valid),
        .o_pixel   (o_pix.pixel_out),
        .o_changed (o_pix.changed)
    );

    assign o_pix.valid = out_valid;

`ifndef SYNTH
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("output valid right after reset");

    a_store_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("texel store written and read in one cycle");

    a_store_only_when_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we || mem_re) |-> en)
        else $error("texel store accessed while pipeline stalled");

    a_changed_has_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && o_pix.changed) |-> (o_pix.pixel_out[31:24] != 8'd0))
        else $error("covered pixel with zero alpha");
`endif

endmodule

// ===== sim/tb_rotated_sprite_alpha_blend.sv =====
module tb_rotated_sprite_alpha_blend;
    import rsab_pkg::*;

    // Cycles the output side keeps ready low in the long hold-off, chosen so
    // that the pipeline fills completely and the input must drop ready.
    localparam int RX_HOLD_CYCLES = 300;
    // Loads leave no trace on the output, so after the last result we let the
    // pipeline settle before touching the registers or ending the run.
    localparam int SETTLE_CYCLES = 12;
    // Longest legal stretch without any beat moving is the hold-off above
    // plus a random stall run; the limit is several times that.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int N_PHASES = 8;
    localparam int PHASE_BEATS = 204;
    localparam int N_DIRECTED = 23;
    // A hit-seeking blend draws screen points until one lands in the sprite.
    localparam int HIT_TRIES = 400;

    // Indexes past the two real registers; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    typedef struct packed {
        t_opcode             op;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [COLOR_W-1:0]  color;
    } t_beat;

    typedef struct packed {
        logic [COLOR_W-1:0]  pixel;
        logic                changed;
    } t_pixel_result;

    // One row of the directed table. Where typed is set the expected result
    // is written out by hand; otherwise the predictor supplies it.
    typedef struct packed {
        t_opcode             op;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [COLOR_W-1:0]  color;
        logic                typed;
        logic [COLOR_W-1:0]  exp_pixel;
        logic                exp_changed;
    } t_stim_row;

    // With cosine 1.0 and sine 0, screen x maps to sprite column 32 + dx for
    // dx >= 0 and 33 + dx for dx < 0, because one half is added before the
    // truncation toward zero; rows behave the same way around pivot row 50.
    // That is how the screen points below were picked.
    t_stim_row directed_rows [N_DIRECTED] = '{
        // Opaque texel in the top left corner replaces the pixel outright.
        '{OP_LOAD,  9'd0,   9'd0,   32'hFF123456, 1'b0, 32'h0,        1'b0},
        '{OP_BLEND, 9'd207, 9'd189, 32'h00C0FFEE, 1'b1, 32'hFF123456, 1'b1},
        // Fully transparent texel in the bottom right corner passes the pixel.
        '{OP_LOAD,  9'd62,  9'd239, 32'h00ABCDEF, 1'b0, 32'h0,        1'b0},
        '{OP_BLEND, 9'd270, 9'd429, 32'h87654321, 1'b1, 32'h87654321, 1'b0},
        // Partial alphas at the other two corners and next to the top left one go through the divide by 255.
        '{OP_LOAD,  9'd1,   9'd0,   32'h80FF0000, 1'b0, 32'h0,        1'b0},
        '{OP_BLEND, 9'd208, 9'd189, 32'hFF00FF00, 1'b0, 32'h0,        1'b0},
        '{OP_LOAD,  9'd62,  9'd0,   32'h01FFFFFF, 1'b0, 32'h0,        1'b0},
        '{OP_BLEND, 9'd270, 9'd189, 32'h00000000, 1'b0, 32'h0,        1'b0},
        '{OP_LOAD,  9'd0,   9'd239, 32'hFE000000, 1'b0, 32'h0,        1'b0},
        '{OP_BLEND, 9'd207, 9'd429, 32'hFFFFFFFF, 1'b0, 32'h0,        1'b0},
        // Loads outside the sprite are dropped and must not alias anything.
        '{OP_LOAD,  9'd63,  9'd0,   32'hFFFFFFFF, 1'b0, 32'h0,        1'b0},
        '{OP_LOAD,  9'd511, 9'd511, 32'hFFFFFFFF, 1'b0, 32'h0,        1'b0},
        '{OP_LOAD,  9'd0,   9'd240, 32'hFFFFFFFF, 1'b0, 32'h0,        1'b0},
        // Points that map just past the right edge, the far screen corners
        // and the coordinates beyond the visible screen all miss the sprite.
        '{OP_BLEND, 9'd271, 9'd189, 32'h13579BDF, 1'b1, 32'h13579BDF, 1'b0},
        '{OP_BLEND, 9'd0,   9'd0,   32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
        '{OP_BLEND, 9'd511, 9'd511, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
        '{OP_BLEND, 9'd479, 9'd479, 32'hA5A5A5A5, 1'b1, 32'hA5A5A5A5, 1'b0},
        // The screen center lands on the pivot, and so does the pixel one
        // up and to the left, since both offsets truncate to zero.
        '{OP_LOAD,  9'd32,  9'd50,  32'h7F3C5A96, 1'b0, 32'h0,        1'b0},
        '{OP_BLEND, 9'd240, 9'd240, 32'h12345678, 1'b0, 32'h0,        1'b0},
        '{OP_BLEND, 9'd239, 9'd239, 32'h12345678, 1'b0, 32'h0,        1'b0},
        // One step past the left, top and bottom edges.
        '{OP_BLEND, 9'd206, 9'd189, 32'h0F0F0F0F, 1'b1, 32'h0F0F0F0F, 1'b0},
        '{OP_BLEND, 9'd207, 9'd188, 32'hF0F0F0F0, 1'b1, 32'hF0F0F0F0, 1'b0},
        '{OP_BLEND, 9'd270, 9'd430, 32'h5A5A5A5A, 1'b1, 32'h5A5A5A5A, 1'b0}
    };

    // Rotation settings per phase: the four right angles, 45 degrees, a
    // random angle (filled in at run time), the raw 16-bit extremes beyond
    // +-1.0, and the degenerate zero matrix that folds everything onto the
    // pivot texel.
    logic signed [TRIG_W-1:0] phase_cos [N_PHASES] = '{
        16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd11585, 16'sd0, 16'sh7FFF, 16'sd0
    };
    logic signed [TRIG_W-1:0] phase_sin [N_PHASES] = '{
        16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd11585, 16'sd0, 16'sh8000, 16'sd0
    };

    // Idle modes, cycled through by phase: none, sender mostly idle,
    // receiver mostly stalling, both now and then.
    int tx_idle_by_mode  [4] = '{0, 84, 0, 13};
    int rx_stall_by_mode [4] = '{0, 0, 84, 13};

    logic i_clk;
    logic i_rst_n;

    rsab_cfg_if cfg_ch ();
    rsab_in_if  pix_in ();
    rsab_out_if pix_out ();

    rotated_sprite_alpha_blend dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    // Shadow of the block: the sprite store, which texels have been loaded,
    // and the two rotation registers.
    logic [COLOR_W-1:0]       texel_shadow [TEXEL_COUNT];
    bit                       texel_loaded [TEXEL_COUNT];
    logic signed [TRIG_W-1:0] cos_q14;
    logic signed [TRIG_W-1:0] sin_q14;

    // Results owed by the block, oldest first.
    t_pixel_result expected_pixels [$];

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int quiet_cycles;
    int beats_counted;
    int blends_sent;
    int results_checked;
    int mismatches;
    int settings_used;
    t_pixel_result want;

    always #6 i_clk = ~i_clk;

    // Inverse rotation of a screen point into sprite space. Integer division
    // in SystemVerilog truncates toward zero, which is what the block does.
    function automatic void map_to_sprite(input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y,
                                          output bit hit, output int unsigned addr);
        longint c, s, dx, dy, sx, sy;
        c  = longint'(cos_q14);
        s  = longint'(sin_q14);
        dx = longint'(x) - CENTER_X;
        dy = longint'(y) - CENTER_Y;
        sx = PIVOT_COL + (dx * c + dy * s + 8192) / 16384;
        sy = PIVOT_ROW + (dy * c - dx * s + 8192) / 16384;
        hit  = (sx >= 0) && (sx < SPRITE_WIDTH) && (sy >= 0) && (sy < SPRITE_HEIGHT);
        addr = hit ? int'(sy * SPRITE_WIDTH + sx) : 0;
    endfunction

    // What the block must return for one blend beat.
    function automatic t_pixel_result blend_over_pixel(input logic [COORD_W-1:0] x,
                                                       input logic [COORD_W-1:0] y,
                                                       input logic [COLOR_W-1:0] dst);
        t_pixel_result    res;
        bit               hit;
        int unsigned      addr;
        logic [COLOR_W-1:0] tex;
        int unsigned      alpha;
        int unsigned      src_c;
        int unsigned      dst_c;
        int               k;
        res.pixel   = dst;
        res.changed = 1'b0;
        map_to_sprite(x, y, hit, addr);
        if (!hit)
            return res;
        tex   = texel_shadow[addr];
        alpha = tex[31:24];
        if (alpha == 0)
            return res;
        res.changed = 1'b1;
        if (alpha == 255) begin
            res.pixel = tex;
            return res;
        end
        res.pixel[31:24] = 8'hFF;
        for (k = 0; k < 3; k++) begin
            src_c = tex[8*k +: 8];
            dst_c = dst[8*k +: 8];
            res.pixel[8*k +: 8] = 8'((src_c * alpha + dst_c * (255 - alpha)) / 255);
        end
        return res;
    endfunction

    // Texel with alpha spread over transparent, opaque and partial.
    function automatic logic [COLOR_W-1:0] random_texel();
        logic [7:0] alpha;
        case ($urandom_range(3))
            0: alpha = 8'h00;
            1: alpha = 8'hFF;
            default: alpha = 8'($urandom);
        endcase
        return {alpha, 24'($urandom)};
    endfunction

    // Offer one beat, hold it until accepted, then update the shadow or
    // queue the expected result. Typed rows bring their own expectation.
    // Afterwards the sender may go idle for a while.
    task automatic send_beat(input t_beat b, input bit typed, input t_pixel_result typed_res);
        t_pixel_result res;
        pix_in.opcode <= b.op;
        pix_in.col    <= b.col;
        pix_in.row    <= b.row;
        pix_in.color  <= b.color;
        pix_in.valid  <= 1'b1;
        @(posedge i_clk);
        while (!pix_in.ready)
            @(posedge i_clk);
        if (b.op == OP_LOAD) begin
            if (b.col < SPRITE_WIDTH && b.row < SPRITE_HEIGHT) begin
                texel_shadow[b.row * SPRITE_WIDTH + b.col] = b.color;
                texel_loaded[b.row * SPRITE_WIDTH + b.col] = 1'b1;
                beats_counted++;
            end
        end else begin
            res = typed ? typed_res : blend_over_pixel(b.col, b.row, b.color);
            expected_pixels.push_back(res);
            beats_counted++;
            blends_sent++;
        end
        if ($urandom_range(99) < tx_idle_pct) begin
            pix_in.valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // A blend at a random screen point. When seeking a hit, points are drawn
    // until one lands in the sprite. A texel that would be read before it
    // was ever loaded gets a load beat first, so the store is never read
    // uninitialized.
    task automatic send_random_blend(input bit seek_hit);
        t_beat       b;
        t_beat       fill;
        bit          hit;
        int unsigned addr;
        int          tries;
        b.op    = OP_BLEND;
        b.color = $urandom;
        tries   = 0;
        do begin
            b.col = 9'($urandom_range(511));
            b.row = 9'($urandom_range(511));
            map_to_sprite(b.col, b.row, hit, addr);
            tries++;
        end while (seek_hit && !hit && tries < HIT_TRIES);
        if (hit && !texel_loaded[addr]) begin
            fill.op    = OP_LOAD;
            fill.col   = 9'(addr % SPRITE_WIDTH);
            fill.row   = 9'(addr / SPRITE_WIDTH);
            fill.color = random_texel();
            send_beat(fill, 1'b0, '0);
        end
        send_beat(b, 1'b0, '0);
    endtask

    // Stop offering beats until every owed result is back, then give any
    // load still in the pipeline time to reach the store.
    task automatic wait_idle();
        pix_in.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write cosine and sine back to back, and optionally poke the spare
    // indexes afterwards so that a write which aliased onto a real register
    // would corrupt it and show up in the results.
    task automatic apply_rotation(input logic signed [TRIG_W-1:0] c,
                                  input logic signed [TRIG_W-1:0] s,
                                  input bit poke_spares);
        logic [CFG_IDX_W-1:0] idx  [4];
        logic [TRIG_W-1:0]    data [4];
        int                   n;
        int                   i;
        idx[0] = REG_COS;     data[0] = c;
        idx[1] = REG_SIN;     data[1] = s;
        idx[2] = REG_SPARE_2; data[2] = 16'($urandom);
        idx[3] = REG_SPARE_3; data[3] = 16'($urandom);
        n = poke_spares ? 4 : 2;
        for (i = 0; i < n; i++) begin
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= data[i];
            cfg_ch.valid <= 1'b1;
            @(posedge i_clk);
            while (!cfg_ch.ready)
                @(posedge i_clk);
            if (idx[i] == REG_COS)
                cos_q14 = data[i];
            else if (idx[i] == REG_SIN)
                sin_q14 = data[i];
        end
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Output side: random stalls by the current mode, plus the long
    // hold-off whenever the main sequence asks for one.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served   <= hold_requests;
            hold_left     <= RX_HOLD_CYCLES;
            pix_out.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            pix_out.ready <= 1'b0;
        end else begin
            pix_out.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Every result beat is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            results_checked++;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing expected: pixel_out %h changed %b",
                         $time, pix_out.pixel_out, pix_out.changed);
            end else begin
                want = expected_pixels.pop_front();
                if (pix_out.pixel_out !== want.pixel) begin
                    mismatches++;
                    $display("%0t: pixel_out expected %h actual %h",
                             $time, want.pixel, pix_out.pixel_out);
                end
                if (pix_out.changed !== want.changed) begin
                    mismatches++;
                    $display("%0t: changed expected %b actual %b",
                             $time, want.changed, pix_out.changed);
                end
            end
        end
    end

    // A run that stops moving beats for too long has hung.
    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results still owed",
                     $time, quiet_cycles, expected_pixels.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_beat         b;
        t_pixel_result typed_res;
        int            r;
        int            phase;
        int            phase_target;
        int            pick;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        pix_in.valid   = 1'b0;
        pix_in.opcode  = OP_LOAD;
        pix_in.col     = '0;
        pix_in.row     = '0;
        pix_in.color   = '0;
        pix_out.ready  = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_COS;
        cfg_ch.data    = '0;
        cos_q14        = COS_RESET;
        sin_q14        = SIN_RESET;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        hold_requests  = 0;
        hold_served    = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        beats_counted  = 0;
        blends_sent    = 0;
        results_checked = 0;
        mismatches     = 0;
        settings_used  = 1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at the reset rotation, so the hand-typed results
        // hold without any register write.
        for (r = 0; r < N_DIRECTED; r++) begin
            b.op      = directed_rows[r].op;
            b.col     = directed_rows[r].col;
            b.row     = directed_rows[r].row;
            b.color   = directed_rows[r].color;
            typed_res.pixel   = directed_rows[r].exp_pixel;
            typed_res.changed = directed_rows[r].exp_changed;
            send_beat(b, directed_rows[r].typed, typed_res);
        end
        wait_idle();

        // Random phases. Each one starts from an idle block, so the drain at
        // the end of a phase is also where the sender pauses until every
        // result is back.
        for (phase = 0; phase < N_PHASES; phase++) begin
            tx_idle_pct  = tx_idle_by_mode[phase % 4];
            rx_stall_pct <= rx_stall_by_mode[phase % 4];
            if (phase == 5)
                apply_rotation(16'($urandom_range(32768)) - 16'sd16384,
                               16'($urandom_range(32768)) - 16'sd16384, 1'b0);
            else
                apply_rotation(phase_cos[phase], phase_sin[phase],
                               phase == 2 || phase == 6);
            // The first phase runs a full-speed sender into a receiver that
            // holds off for a long stretch, so the pipeline fills and the
            // input side has to stall.
            if (phase == 0)
                hold_requests <= hold_requests + 1;
            phase_target = beats_counted + PHASE_BEATS;
            while (beats_counted < phase_target) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    send_random_blend(1'b1);
                end else if (pick < 80) begin
                    send_random_blend(1'b0);
                end else begin
                    // Mostly in-sprite loads that overwrite texels, with some
                    // anywhere on the coordinate range.
                    b.op    = OP_LOAD;
                    b.color = random_texel();
                    if ($urandom_range(99) < 85) begin
                        b.col = 9'($urandom_range(SPRITE_WIDTH - 1));
                        b.row = 9'($urandom_range(SPRITE_HEIGHT - 1));
                    end else begin
                        b.col = 9'($urandom_range(511));
                        b.row = 9'($urandom_range(511));
                    end
                    send_beat(b, 1'b0, '0);
                end
            end
            wait_idle();
        end

        $display("Sent %0d counted input beats, %0d of them blends, under %0d rotation settings.",
                 beats_counted, blends_sent, settings_used);
        $display("Checked %0d result beats across all idle modes; %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
